// ===== rtl/lfrp_pkg.sv =====
// shared types, codes and constants for the link failover retry policy
`default_nettype none

package lfrp_pkg;

    localparam int NUM_LINKS    = 4;
    localparam int LINK_SLOTS   = 4;
    localparam int USABLE_LINKS = (NUM_LINKS < LINK_SLOTS) ? NUM_LINKS : LINK_SLOTS;
    localparam logic [1:0] LAST_LINK = 2'(USABLE_LINKS - 1);

    localparam int TIME_W  = 40;
    localparam int DELAY_W = 24;

    localparam logic [3:0]  RETRIES_RESET   = 4'd3;
    localparam logic [23:0] PENALTY_RESET   = 24'd300000;
    localparam logic [23:0] SRV_LIMIT_RESET = 24'd120000;
    localparam logic [23:0] RESCAN_RESET    = 24'd500;

    typedef enum logic [2:0] {
        K_START  = 3'd0,
        K_SCAN   = 3'd1,
        K_DISC   = 3'd2,
        K_ADDR   = 3'd3,
        K_SRV    = 3'd4,
        K_WD     = 3'd5,
        K_TIMER  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE            = 3'd0,
        ACT_SCAN            = 3'd1,
        ACT_CONNECT         = 3'd2,
        ACT_DISCONNECT      = 3'd3,
        ACT_SCAN_LATER      = 3'd4,
        ACT_RECONNECT_LATER = 3'd5
    } act_t;

    typedef enum logic [7:0] {
        CFG_RETRIES   = 8'd0,
        CFG_PENALTY   = 8'd1,
        CFG_SRV_LIMIT = 8'd2,
        CFG_RESCAN    = 8'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_WD_DIFF,
        ST_WD_CMP,
        ST_PENALIZE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    function automatic logic [23:0] backoff(input logic [3:0] n);
        logic [23:0] v;
        case (n)
            4'd0:    v = 24'd1000;
            4'd1:    v = 24'd2000;
            4'd2:    v = 24'd4000;
            4'd3:    v = 24'd8000;
            default: v = 24'd30000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lfrp_alu.sv =====
// shared 40-bit add/subtract unit with carry/borrow out
`default_nettype none

module lfrp_alu (
    input  wire lfrp_pkg::alu_op_t op,
    input  wire logic [39:0]       a,
    input  wire logic [39:0]       b,
    output logic [40:0]            y
);

    always_comb
    begin
        case (op)
            lfrp_pkg::ALU_ADD: y = {1'b0, a} + {1'b0, b};
            lfrp_pkg::ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default:           y = {1'b0, a};
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/link_failover_retry_policy.sv =====
// top level of the link failover retry policy sequencer
`default_nettype none

// An event is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be stalled.
// Start, got address, server status, timer and unknown events, a disconnect
// that retries and a watchdog that is not armed give their result in the cycle
// after acceptance; a disconnect that abandons the link passes through the
// penalize state; a scan checks the links one at a time (up to four) in the
// pick state; an armed watchdog passes the difference and compare states,
// leaving early when the outage is too short, and the penalize state when it
// fires. The single 40-bit add/subtract unit does every penalty compare, the
// server-down elapsed check and the saturating penalty deadline, one per cycle.
// busy falls in the cycle done is high, so the next event may be offered then.
// link_index and link_up always show the current link and connected flag.

module link_failover_retry_policy (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic [39:0] now_ms,
    input  wire logic [3:0]  seen_mask,
    input  wire logic        server_reachable,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output logic             done,
    output logic [2:0]       action,
    output logic [1:0]       link_index,
    output logic [23:0]      sched_delay,
    output logic             link_up
);

    lfrp_pkg::state_t state_reg, state_next;

    logic [3:0]  retries_reg;
    logic [23:0] penalty_ms_reg;
    logic [23:0] srv_limit_reg;
    logic [23:0] rescan_reg;

    logic [39:0] pen_reg [4];
    logic [39:0] pen_next [4];
    logic [1:0]  cur_reg, cur_next;
    logic [3:0]  fail_reg, fail_next;
    logic [2:0]  round_reg, round_next;
    logic [2:0]  switch_reg, switch_next;
    logic        conn_reg, conn_next;
    logic        switching_reg, switching_next;
    logic        srv_up_reg, srv_up_next;
    logic [39:0] down_reg, down_next;
    logic        pend_reg, pend_next;

    lfrp_pkg::kind_t kind_reg, kind_next;
    logic [39:0] now_reg, now_next;
    logic [3:0]  seen_reg, seen_next;
    logic [39:0] diff_reg, diff_next;
    logic [1:0]  idx_reg, idx_next;
    logic        fbv_reg, fbv_next;
    logic [1:0]  fb_reg, fb_next;

    logic            done_reg, done_next;
    lfrp_pkg::act_t  act_reg, act_next;
    logic [23:0]     delay_reg, delay_next;

    lfrp_pkg::alu_op_t alu_op;
    logic [39:0]       alu_a;
    logic [39:0]       alu_b;
    logic [40:0]       alu_y;
    logic              borrow;
    logic [39:0]       sat_sum;

    logic        accept;
    logic [3:0]  fail_inc;
    logic        abandon;
    logic        wd_armed;
    logic        pick_hit;
    logic        pick_any;
    logic [1:0]  pick_idx;

    assign busy      = (state_reg != lfrp_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign done        = done_reg;
    assign action      = act_reg;
    assign sched_delay = delay_reg;
    assign link_index  = cur_reg;
    assign link_up     = conn_reg;

    assign fail_inc = (fail_reg == 4'd15) ? 4'd15 : fail_reg + 4'd1;
    assign abandon  = !((fail_inc < retries_reg) || (lfrp_pkg::NUM_LINKS == 1));
    assign wd_armed = conn_reg && !srv_up_reg && (lfrp_pkg::NUM_LINKS >= 2)
                      && (int'(switch_reg) < lfrp_pkg::NUM_LINKS);

    assign borrow   = alu_y[40];
    assign sat_sum  = alu_y[40] ? {40{1'b1}} : alu_y[39:0];
    assign pick_hit = seen_reg[idx_reg] && !borrow;
    assign pick_any = fbv_reg || seen_reg[idx_reg];
    assign pick_idx = fbv_reg ? fb_reg : idx_reg;

    // operand select for the shared unit
    always_comb
    begin
        case (state_reg)
            lfrp_pkg::ST_PICK:
            begin
                alu_op = lfrp_pkg::ALU_SUB;
                alu_a  = now_reg;
                alu_b  = pen_reg[idx_reg];
            end
            lfrp_pkg::ST_WD_DIFF:
            begin
                alu_op = lfrp_pkg::ALU_SUB;
                alu_a  = now_reg;
                alu_b  = down_reg;
            end
            lfrp_pkg::ST_WD_CMP:
            begin
                alu_op = lfrp_pkg::ALU_SUB;
                alu_a  = diff_reg;
                alu_b  = {16'd0, srv_limit_reg};
            end
            default:
            begin
                alu_op = lfrp_pkg::ALU_ADD;
                alu_a  = now_reg;
                alu_b  = {16'd0, penalty_ms_reg};
            end
        endcase
    end

    lfrp_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfrp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        lfrp_pkg::K_SCAN:
                            state_next = lfrp_pkg::ST_PICK;
                        lfrp_pkg::K_DISC:
                            if (!switching_reg && abandon)
                                state_next = lfrp_pkg::ST_PENALIZE;
                        lfrp_pkg::K_WD:
                            if (wd_armed)
                                state_next = lfrp_pkg::ST_WD_DIFF;
                        default:
                            state_next = lfrp_pkg::ST_IDLE;
                    endcase
                end
            end
            lfrp_pkg::ST_PICK:
                if (pick_hit || idx_reg == lfrp_pkg::LAST_LINK)
                    state_next = lfrp_pkg::ST_IDLE;
            lfrp_pkg::ST_WD_DIFF:
                state_next = borrow ? lfrp_pkg::ST_IDLE : lfrp_pkg::ST_WD_CMP;
            lfrp_pkg::ST_WD_CMP:
                state_next = borrow ? lfrp_pkg::ST_IDLE : lfrp_pkg::ST_PENALIZE;
            lfrp_pkg::ST_PENALIZE:
                state_next = lfrp_pkg::ST_IDLE;
            default:
                state_next = lfrp_pkg::ST_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pen_next[i] = pen_reg[i];
        end
        cur_next       = cur_reg;
        fail_next      = fail_reg;
        round_next     = round_reg;
        switch_next    = switch_reg;
        conn_next      = conn_reg;
        switching_next = switching_reg;
        srv_up_next    = srv_up_reg;
        down_next      = down_reg;
        pend_next      = pend_reg;
        kind_next      = kind_reg;
        now_next       = now_reg;
        seen_next      = seen_reg;
        diff_next      = diff_reg;
        idx_next       = idx_reg;
        fbv_next       = fbv_reg;
        fb_next        = fb_reg;
        done_next      = 1'b0;
        act_next       = act_reg;
        delay_next     = delay_reg;

        case (state_reg)
            lfrp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = lfrp_pkg::kind_t'(kind);
                    now_next  = now_ms;
                    seen_next = seen_mask;
                    idx_next  = 2'd0;
                    fbv_next  = 1'b0;
                    case (kind)
                        lfrp_pkg::K_START:
                        begin
                            done_next  = 1'b1;
                            act_next   = lfrp_pkg::ACT_SCAN;
                            delay_next = 24'd0;
                        end
                        lfrp_pkg::K_SCAN:
                            done_next = 1'b0;
                        lfrp_pkg::K_DISC:
                        begin
                            conn_next = 1'b0;
                            if (switching_reg)
                            begin
                                switching_next = 1'b0;
                                done_next      = 1'b1;
                                act_next       = lfrp_pkg::ACT_SCAN;
                                delay_next     = 24'd0;
                            end
                            else if (!abandon)
                            begin
                                fail_next  = fail_inc;
                                pend_next  = 1'b1;
                                done_next  = 1'b1;
                                act_next   = lfrp_pkg::ACT_RECONNECT_LATER;
                                delay_next = lfrp_pkg::backoff(fail_inc - 4'd1);
                            end
                            else
                            begin
                                fail_next = 4'd0;
                                pend_next = 1'b0;
                            end
                        end
                        lfrp_pkg::K_ADDR:
                        begin
                            conn_next  = 1'b1;
                            fail_next  = 4'd0;
                            down_next  = now_ms;
                            done_next  = 1'b1;
                            act_next   = lfrp_pkg::ACT_NONE;
                            delay_next = 24'd0;
                        end
                        lfrp_pkg::K_SRV:
                        begin
                            if (server_reachable)
                                switch_next = 3'd0;
                            else if (srv_up_reg)
                                down_next = now_ms;
                            srv_up_next = server_reachable;
                            done_next   = 1'b1;
                            act_next    = lfrp_pkg::ACT_NONE;
                            delay_next  = 24'd0;
                        end
                        lfrp_pkg::K_WD:
                        begin
                            if (!wd_armed)
                            begin
                                done_next  = 1'b1;
                                act_next   = lfrp_pkg::ACT_NONE;
                                delay_next = 24'd0;
                            end
                        end
                        lfrp_pkg::K_TIMER:
                        begin
                            done_next  = 1'b1;
                            act_next   = pend_reg ? lfrp_pkg::ACT_CONNECT : lfrp_pkg::ACT_SCAN;
                            delay_next = 24'd0;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            act_next   = lfrp_pkg::ACT_NONE;
                            delay_next = 24'd0;
                        end
                    endcase
                end
            end
            lfrp_pkg::ST_PICK:
            begin
                if (pick_hit || (idx_reg == lfrp_pkg::LAST_LINK && pick_any))
                begin
                    round_next = 3'd0;
                    fail_next  = 4'd0;
                    cur_next   = pick_hit ? idx_reg : pick_idx;
                    done_next  = 1'b1;
                    act_next   = lfrp_pkg::ACT_CONNECT;
                    delay_next = 24'd0;
                end
                else if (idx_reg == lfrp_pkg::LAST_LINK)
                begin
                    done_next = 1'b1;
                    if (lfrp_pkg::NUM_LINKS == 1)
                    begin
                        cur_next   = 2'd0;
                        act_next   = lfrp_pkg::ACT_CONNECT;
                        delay_next = 24'd0;
                    end
                    else
                    begin
                        delay_next = lfrp_pkg::backoff({1'b0, round_reg});
                        round_next = (round_reg == 3'd7) ? 3'd7 : round_reg + 3'd1;
                        pend_next  = 1'b0;
                        act_next   = lfrp_pkg::ACT_SCAN_LATER;
                    end
                end
                else
                begin
                    if (seen_reg[idx_reg] && !fbv_reg)
                    begin
                        fbv_next = 1'b1;
                        fb_next  = idx_reg;
                    end
                    idx_next = idx_reg + 2'd1;
                end
            end
            lfrp_pkg::ST_WD_DIFF:
            begin
                diff_next = alu_y[39:0];
                if (borrow)
                begin
                    done_next  = 1'b1;
                    act_next   = lfrp_pkg::ACT_NONE;
                    delay_next = 24'd0;
                end
            end
            lfrp_pkg::ST_WD_CMP:
            begin
                if (borrow)
                begin
                    done_next  = 1'b1;
                    act_next   = lfrp_pkg::ACT_NONE;
                    delay_next = 24'd0;
                end
            end
            lfrp_pkg::ST_PENALIZE:
            begin
                pen_next[cur_reg] = sat_sum;
                done_next         = 1'b1;
                if (kind_reg == lfrp_pkg::K_WD)
                begin
                    switch_next    = (switch_reg == 3'd7) ? 3'd7 : switch_reg + 3'd1;
                    switching_next = 1'b1;
                    act_next       = lfrp_pkg::ACT_DISCONNECT;
                    delay_next     = 24'd0;
                end
                else
                begin
                    act_next   = lfrp_pkg::ACT_SCAN_LATER;
                    delay_next = rescan_reg;
                end
            end
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfrp_pkg::ST_IDLE;
            retries_reg   <= lfrp_pkg::RETRIES_RESET;
            penalty_ms_reg <= lfrp_pkg::PENALTY_RESET;
            srv_limit_reg <= lfrp_pkg::SRV_LIMIT_RESET;
            rescan_reg    <= lfrp_pkg::RESCAN_RESET;
            for (int i = 0; i < 4; i++)
            begin
                pen_reg[i] <= 40'd0;
            end
            cur_reg       <= 2'd0;
            fail_reg      <= 4'd0;
            round_reg     <= 3'd0;
            switch_reg    <= 3'd0;
            conn_reg      <= 1'b0;
            switching_reg <= 1'b0;
            srv_up_reg    <= 1'b0;
            down_reg      <= 40'd0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            act_reg       <= lfrp_pkg::ACT_NONE;
            delay_reg     <= 24'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lfrp_pkg::CFG_RETRIES:   retries_reg    <= cfg_data[3:0];
                    lfrp_pkg::CFG_PENALTY:   penalty_ms_reg <= cfg_data;
                    lfrp_pkg::CFG_SRV_LIMIT: srv_limit_reg  <= cfg_data;
                    lfrp_pkg::CFG_RESCAN:    rescan_reg     <= cfg_data;
                    default:                 retries_reg    <= retries_reg;
                endcase
            end
            for (int i = 0; i < 4; i++)
            begin
                pen_reg[i] <= pen_next[i];
            end
            cur_reg       <= cur_next;
            fail_reg      <= fail_next;
            round_reg     <= round_next;
            switch_reg    <= switch_next;
            conn_reg      <= conn_next;
            switching_reg <= switching_next;
            srv_up_reg    <= srv_up_next;
            down_reg      <= down_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            act_reg       <= act_next;
            delay_reg     <= delay_next;
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        now_reg  <= now_next;
        seen_reg <= seen_next;
        diff_reg <= diff_next;
        idx_reg  <= idx_next;
        fbv_reg  <= fbv_next;
        fb_reg   <= fb_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lfrp_checker.sv =====
// port-level checker for the link failover retry policy, bound to the top level
`default_nettype none

module lfrp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  action,
    input wire logic [23:0] sched_delay
);

    // an accepted transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither answered nor in progress");

    // work in progress ends only with a result
    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // no result while still working
    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result shown while busy");

    // only scheduled actions carry a delay
    a_delay_only_scheduled: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != lfrp_pkg::ACT_SCAN_LATER
              && action != lfrp_pkg::ACT_RECONNECT_LATER) |-> (sched_delay == 24'd0))
        else $error("delay on an unscheduled action");

endmodule

bind link_failover_retry_policy lfrp_checker u_lfrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .action      (action),
    .sched_delay (sched_delay)
);

`default_nettype wire

// ===== dv/tb_link_failover_retry_policy.sv =====
// testbench for the link failover retry policy checked against a cycle-free predictor
`timescale 1ns / 1ps

module tb_link_failover_retry_policy;

    localparam int          STALL_LIMIT    = 5000;
    localparam int          RANDOM_EVENTS  = 220;
    localparam logic [2:0]  KIND_UNDEFINED = 3'd7;
    localparam logic [7:0]  CFG_UNMAPPED   = 8'd9;
    localparam logic [39:0] TIME_MAX       = 40'hFF_FFFF_FFFF;
    localparam logic [23:0] BACKOFF_MS [5] =
        '{24'd1000, 24'd2000, 24'd4000, 24'd8000, 24'd30000};

    typedef struct packed {
        logic [2:0]  kind;
        logic [39:0] now;
        logic [3:0]  mask;
        logic        reach;
    } policy_event_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  link;
        logic [23:0] delay;
        logic        up;
    } policy_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  kind = '0;
    logic [39:0] now_ms = '0;
    logic [3:0]  seen_mask = '0;
    logic        server_reachable = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic [2:0]  action;
    logic [1:0]  link_index;
    logic [23:0] sched_delay;
    logic        link_up;

    link_failover_retry_policy u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .now_ms           (now_ms),
        .seen_mask        (seen_mask),
        .server_reachable (server_reachable),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .action           (action),
        .link_index       (link_index),
        .sched_delay      (sched_delay),
        .link_up          (link_up)
    );

    always #5 clk = ~clk;

    // predictor state and register copies
    logic [3:0]  cfg_retries    = lfrp_pkg::RETRIES_RESET;
    logic [23:0] cfg_penalty    = lfrp_pkg::PENALTY_RESET;
    logic [23:0] cfg_srv_limit  = lfrp_pkg::SRV_LIMIT_RESET;
    logic [23:0] cfg_rescan     = lfrp_pkg::RESCAN_RESET;
    logic [39:0] pen_until [4]  = '{default: '0};
    logic [1:0]  cur_link       = '0;
    logic [3:0]  fail_cnt       = '0;
    logic [2:0]  scan_rnd       = '0;
    logic [2:0]  sw_cnt         = '0;
    logic        conn           = 1'b0;
    logic        switching_link = 1'b0;
    logic        srv_up         = 1'b0;
    logic [39:0] down_since     = '0;
    logic        pending_connect = 1'b0;

    policy_event_t  event_queue[$];
    policy_result_t expected_results[$];
    policy_event_t  offered;
    logic [39:0]    sim_ms = '0;
    int             idle_pct = 0;
    int             events_queued = 0;
    int             events_accepted = 0;
    int             results_checked = 0;
    int             reg_writes = 0;
    int             settings_run = 1;
    int             error_count = 0;
    int             stall_cycles = 0;
    int             action_seen [8] = '{default: 0};

    function automatic logic [23:0] backoff_ms(input int n);
        return BACKOFF_MS[n > 4 ? 4 : n];
    endfunction

    function automatic void penalize_link(input logic [39:0] now);
        logic [40:0] sum;
        sum = {1'b0, now} + {17'd0, cfg_penalty};
        pen_until[cur_link] = sum[40] ? TIME_MAX : sum[39:0];
    endfunction

    function automatic policy_result_t policy_step(input policy_event_t ev);
        policy_result_t r;
        int pick;
        int fallback;
        r.action = lfrp_pkg::ACT_NONE;
        r.delay  = '0;
        case (ev.kind)
            lfrp_pkg::K_START: r.action = lfrp_pkg::ACT_SCAN;
            lfrp_pkg::K_SCAN:
            begin
                pick = -1;
                fallback = -1;
                for (int i = 0; i < lfrp_pkg::USABLE_LINKS; i++)
                begin
                    if (ev.mask[i] && pick < 0)
                    begin
                        if (fallback < 0) fallback = i;
                        if (ev.now >= pen_until[i]) pick = i;
                    end
                end
                if (pick < 0) pick = fallback;
                if (pick >= 0)
                begin
                    scan_rnd = '0;
                    fail_cnt = '0;
                    cur_link = pick[1:0];
                    r.action = lfrp_pkg::ACT_CONNECT;
                end
                else if (lfrp_pkg::NUM_LINKS == 1)
                begin
                    cur_link = '0;
                    r.action = lfrp_pkg::ACT_CONNECT;
                end
                else
                begin
                    r.delay = backoff_ms(int'(scan_rnd));
                    if (scan_rnd != 3'd7) scan_rnd++;
                    pending_connect = 1'b0;
                    r.action = lfrp_pkg::ACT_SCAN_LATER;
                end
            end
            lfrp_pkg::K_DISC:
            begin
                conn = 1'b0;
                if (switching_link)
                begin
                    switching_link = 1'b0;
                    r.action = lfrp_pkg::ACT_SCAN;
                end
                else
                begin
                    if (fail_cnt != 4'd15) fail_cnt++;
                    if (fail_cnt < cfg_retries || lfrp_pkg::NUM_LINKS == 1)
                    begin
                        r.delay = backoff_ms(int'(fail_cnt) - 1);
                        pending_connect = 1'b1;
                        r.action = lfrp_pkg::ACT_RECONNECT_LATER;
                    end
                    else
                    begin
                        penalize_link(ev.now);
                        fail_cnt = '0;
                        pending_connect = 1'b0;
                        r.delay = cfg_rescan;
                        r.action = lfrp_pkg::ACT_SCAN_LATER;
                    end
                end
            end
            lfrp_pkg::K_ADDR:
            begin
                conn = 1'b1;
                fail_cnt = '0;
                down_since = ev.now;
            end
            lfrp_pkg::K_SRV:
            begin
                if (ev.reach) sw_cnt = '0;
                else if (srv_up) down_since = ev.now;
                srv_up = ev.reach;
            end
            lfrp_pkg::K_WD:
            begin
                if (conn && !srv_up && lfrp_pkg::NUM_LINKS >= 2
                    && int'(sw_cnt) < lfrp_pkg::NUM_LINKS && ev.now >= down_since
                    && (ev.now - down_since) >= {16'd0, cfg_srv_limit})
                begin
                    penalize_link(ev.now);
                    if (sw_cnt != 3'd7) sw_cnt++;
                    switching_link = 1'b1;
                    r.action = lfrp_pkg::ACT_DISCONNECT;
                end
            end
            lfrp_pkg::K_TIMER:
                r.action = pending_connect ? lfrp_pkg::ACT_CONNECT : lfrp_pkg::ACT_SCAN;
            default: r.action = lfrp_pkg::ACT_NONE;
        endcase
        r.link = cur_link;
        r.up   = conn;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want_v,
                                        input logic [23:0] got_v);
        if (got_v !== want_v)
        begin
            error_count++;
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(policy_step(offered));
                events_accepted++;
            end
            if (!start || !busy)
            begin
                if (event_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    offered = event_queue.pop_front();
                    start            <= 1'b1;
                    kind             <= offered.kind;
                    now_ms           <= offered.now;
                    seen_mask        <= offered.mask;
                    server_reachable <= offered.reach;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        policy_result_t want;
        if (rst_n && done)
        begin
            action_seen[action]++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected transaction: action %0d link %0d delay %0d up %0d",
                         $time, action, link_index, sched_delay, link_up);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("action", 24'(want.action), 24'(action));
                check_field("link_index", 24'(want.link), 24'(link_index));
                check_field("sched_delay", want.delay, sched_delay);
                check_field("link_up", 24'(want.up), 24'(link_up));
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_event(input logic [2:0] k, input logic [39:0] t, input logic [3:0] m,
                              input logic rch);
        policy_event_t ev;
        ev.kind  = k;
        ev.now   = t;
        ev.mask  = m;
        ev.reach = rch;
        event_queue.push_back(ev);
        events_queued++;
    endtask

    // advance the event clock, mostly forward, rarely jumping anywhere
    task automatic add_event(input logic [2:0] k, input logic [3:0] m, input logic rch);
        int r;
        r = $urandom_range(99);
        if (r < 50)
            sim_ms += 40'($urandom_range(2000));
        else if (r < 85)
            sim_ms += 40'($urandom_range(300000));
        else if (r < 98)
            sim_ms += 40'($urandom_range(24'hFF_FFFF));
        else
            sim_ms = 40'({$urandom(), $urandom()});
        push_event(k, sim_ms, m, rch);
    endtask

    task automatic add_episode();
        if ($urandom_range(99) < 15)
        begin
            repeat (3)
                add_event(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)));
        end
        else
        begin
            add_event(lfrp_pkg::K_START, 4'($urandom_range(15)), 1'($urandom_range(1)));
            if ($urandom_range(99) < 20)
                add_event(lfrp_pkg::K_SCAN, 4'd0, 1'($urandom_range(1)));
            add_event(lfrp_pkg::K_SCAN, 4'($urandom_range(1, 15)), 1'($urandom_range(1)));
            add_event(lfrp_pkg::K_ADDR, 4'($urandom_range(15)), 1'($urandom_range(1)));
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(3))
                    0: add_event(lfrp_pkg::K_SRV, 4'($urandom_range(15)), 1'b1);
                    1: add_event(lfrp_pkg::K_SRV, 4'($urandom_range(15)), 1'b0);
                    default: add_event(lfrp_pkg::K_WD, 4'($urandom_range(15)),
                                       1'($urandom_range(1)));
                endcase
            end
            repeat ($urandom_range(1, 4))
            begin
                add_event(lfrp_pkg::K_DISC, 4'($urandom_range(15)), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    add_event(lfrp_pkg::K_TIMER, 4'($urandom_range(15)),
                              1'($urandom_range(1)));
                if ($urandom_range(99) < 30)
                    add_event(lfrp_pkg::K_SCAN, 4'($urandom_range(15)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_queue.size() != 0 || start || busy || expected_results.size() != 0);
        @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [7:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready && cfg_index == idx && cfg_data == value));
        case (idx)
            lfrp_pkg::CFG_RETRIES:   cfg_retries   = value[3:0];
            lfrp_pkg::CFG_PENALTY:   cfg_penalty   = value;
            lfrp_pkg::CFG_SRV_LIMIT: cfg_srv_limit = value;
            lfrp_pkg::CFG_RESCAN:    cfg_rescan    = value;
            default:                 ;
        endcase
        reg_writes++;
    endtask

    task automatic run_random_phase(input logic [3:0] retries, input logic [23:0] penalty,
                                    input logic [23:0] limit, input logic [23:0] rescan,
                                    input int pct);
        int target;
        wait_drained();
        write_reg(lfrp_pkg::CFG_RETRIES, {20'd0, retries});
        write_reg(lfrp_pkg::CFG_PENALTY, penalty);
        write_reg(lfrp_pkg::CFG_SRV_LIMIT, limit);
        write_reg(lfrp_pkg::CFG_RESCAN, rescan);
        cfg_valid <= 1'b0;
        settings_run++;
        idle_pct = pct;
        target = events_queued + RANDOM_EVENTS;
        while (events_queued < target)
            add_episode();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed events under reset register values
        idle_pct = 0;
        push_event(lfrp_pkg::K_START, 40'd0, 4'hF, 1'b1);
        push_event(lfrp_pkg::K_TIMER, 40'd0, 4'h0, 1'b0);
        push_event(KIND_UNDEFINED, 40'd10, 4'hF, 1'b1);
        repeat (6) push_event(lfrp_pkg::K_SCAN, 40'd20, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_SCAN, 40'd100, 4'hF, 1'b0);
        push_event(lfrp_pkg::K_ADDR, 40'd1000, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_SRV, 40'd2000, 4'h0, 1'b1);
        push_event(lfrp_pkg::K_SRV, 40'd3000, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_WD, 40'd50000, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_WD, 40'd2000, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_WD, 40'd200000, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_DISC, 40'd200010, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_SCAN, 40'd200020, 4'b0001, 1'b0);
        push_event(lfrp_pkg::K_SCAN, 40'd200030, 4'b1001, 1'b0);
        push_event(lfrp_pkg::K_DISC, 40'd200040, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_TIMER, 40'd201040, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_DISC, 40'd201050, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_DISC, TIME_MAX - 40'd16, 4'h0, 1'b0);
        push_event(lfrp_pkg::K_SCAN, TIME_MAX, 4'b1000, 1'b1);
        push_event(lfrp_pkg::K_TIMER, TIME_MAX, 4'hF, 1'b1);

        run_random_phase(4'd1, 24'd0, 24'd0, 24'd0, 60);
        run_random_phase(4'd15, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0);
        run_random_phase(4'd0, 24'($urandom_range(600000)), 24'($urandom_range(1000, 200000)),
                         24'($urandom), 30);

        wait_drained();
        write_reg(CFG_UNMAPPED, 24'($urandom));
        cfg_valid <= 1'b0;
        run_random_phase(4'($urandom_range(2, 6)), 24'($urandom), 24'($urandom_range(200000)),
                         24'($urandom), 0);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d events, %0d results checked, %0d register settings, %0d writes",
                 events_accepted, results_checked, settings_run, reg_writes);
        $display("actions: none %0d scan %0d connect %0d disconnect %0d rescan %0d retry %0d",
                 action_seen[lfrp_pkg::ACT_NONE], action_seen[lfrp_pkg::ACT_SCAN],
                 action_seen[lfrp_pkg::ACT_CONNECT], action_seen[lfrp_pkg::ACT_DISCONNECT],
                 action_seen[lfrp_pkg::ACT_SCAN_LATER],
                 action_seen[lfrp_pkg::ACT_RECONNECT_LATER]);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
